>>> rtl/spi_pkg.sv
package spi_pkg;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [47:0] wide_t;

    typedef struct packed {
        fix_t pos_x;
        fix_t pos_y;
        fix_t pos_z;
        fix_t vel_x;
        fix_t vel_y;
        fix_t vel_z;
        fix_t eval_vel_x;
        fix_t eval_vel_y;
        fix_t eval_vel_z;
        fix_t acc_x;
        fix_t acc_y;
        fix_t acc_z;
    } spi_in_t;

    typedef struct packed {
        fix_t new_pos_x;
        fix_t new_pos_y;
        fix_t new_pos_z;
        fix_t new_vel_x;
        fix_t new_vel_y;
        fix_t new_vel_z;
        fix_t new_eval_x;
        fix_t new_eval_y;
        fix_t new_eval_z;
    } spi_out_t;

    typedef struct packed {
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
        logic [47:0]      grav;
        logic [30:0]      limit;
    } cfg_t;

    // one classified particle between front and back
    typedef struct packed {
        logic [63:0]      sum;
        logic             clamp;
        logic [2:0][61:0] num;
        logic [2:0]       neg;
        logic [2:0][31:0] acc;
        logic [2:0][47:0] extra;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } q_item_t;

    typedef enum logic [2:0] {
        REG_WALL_MIN_X  = 3'd0,
        REG_WALL_MIN_Y  = 3'd1,
        REG_WALL_MIN_Z  = 3'd2,
        REG_WALL_MAX_X  = 3'd3,
        REG_WALL_MAX_Y  = 3'd4,
        REG_WALL_MAX_Z  = 3'd5,
        REG_GRAVITY     = 3'd6,
        REG_ACCEL_LIMIT = 3'd7
    } reg_idx_t;

    localparam logic [30:0]        LIMIT_RESET = 31'd19660800;
    localparam logic signed [24:0] DT_Q32      = 25'sd12884902;
    localparam logic signed [47:0] WALL_K      = 48'sd80;
    localparam int                 WALL_DAMP_SH = 8;
    localparam int                 SQ_STEPS    = 32;
    localparam int                 DIV_STEPS   = 31;
    localparam int                 QDEPTH      = 4;

    function automatic fix_t sat32(input wide_t v);
        if (v > 48'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -48'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

>>> rtl/spi_front.sv
module spi_front
    import spi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  spi_in_t req,
    input  cfg_t    cfg,
    output logic    push,
    output q_item_t push_item
);

    logic             f1_vld_reg;
    logic [2:0][62:0] f1_sq_reg;
    logic [61:0]      f1_lim2_reg;
    q_item_t          f1_it_reg;

    fix_t             p [3];
    fix_t             v [3];
    fix_t             e [3];
    fix_t             a [3];
    logic [2:0][62:0] sq_next;
    q_item_t          it_next;

    assign p[0] = req.pos_x;
    assign p[1] = req.pos_y;
    assign p[2] = req.pos_z;
    assign v[0] = req.vel_x;
    assign v[1] = req.vel_y;
    assign v[2] = req.vel_z;
    assign e[0] = req.eval_vel_x;
    assign e[1] = req.eval_vel_y;
    assign e[2] = req.eval_vel_z;
    assign a[0] = req.acc_x;
    assign a[1] = req.acc_y;
    assign a[2] = req.acc_z;

    always_comb
    begin
        logic [31:0]        m;
        logic signed [47:0] pen_lo;
        logic signed [47:0] pen_hi;
        logic signed [47:0] damp;
        logic signed [47:0] term_lo;
        logic signed [47:0] term_hi;
        logic signed [47:0] g;
        logic signed [47:0] two;
        two = 48'sd2 <<< FRAC_BITS;
        it_next = '0;
        sq_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = a[i][31] ? 32'(-a[i]) : a[i];
            sq_next[i] = 63'(64'(m) * 64'(m));
            it_next.num[i] = 62'(64'(m) * 64'(cfg.limit));
            it_next.neg[i] = a[i][31];
            it_next.acc[i] = a[i];
            it_next.pos[i] = p[i];
            it_next.vel[i] = v[i];
            // penalty terms, one per wall, both may act
            pen_lo = two - (48'(p[i]) - 48'($signed(cfg.lo[i])));
            pen_hi = two - (48'($signed(cfg.hi[i])) - 48'(p[i]));
            damp = 48'(e[i]) <<< WALL_DAMP_SH;
            term_lo = (pen_lo > 48'sd0) ? (WALL_K * pen_lo - damp) : 48'sd0;
            term_hi = (pen_hi > 48'sd0) ? -(WALL_K * pen_hi + damp) : 48'sd0;
            g = 48'($signed(cfg.grav[16*i +: 16])) <<< (FRAC_BITS - 8);
            it_next.extra[i] = term_lo + term_hi + g;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_vld_reg <= 1'b0;
        else
            f1_vld_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f1_sq_reg   <= sq_next;
            f1_lim2_reg <= 62'(64'(cfg.limit) * 64'(cfg.limit));
            f1_it_reg   <= it_next;
        end
    end

    always_comb
    begin
        push_item       = f1_it_reg;
        push_item.sum   = 64'(f1_sq_reg[0]) + 64'(f1_sq_reg[1]) + 64'(f1_sq_reg[2]);
        push_item.clamp = push_item.sum > 64'(f1_lim2_reg);
    end

    assign push = f1_vld_reg;

endmodule

>>> rtl/spi_queue.sv
module spi_queue
    import spi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output q_item_t pop_item,
    output logic    empty,
    output logic    afull
);

    localparam int AW = $clog2(QDEPTH);

    q_item_t         mem [QDEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            do_pop;

    assign empty    = (count_reg == '0);
    assign afull    = (count_reg >= (AW+1)'(QDEPTH - 1));
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/spi_back.sv
module spi_back
    import spi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_vld,
    input  q_item_t  in_item,
    output logic     done,
    output spi_out_t res
);

    // square root: one result bit per stage
    logic             sq_vld_reg  [SQ_STEPS+1];
    q_item_t          sq_it_reg   [SQ_STEPS+1];
    logic [63:0]      sq_v_reg    [SQ_STEPS+1];
    logic [33:0]      sq_rem_reg  [SQ_STEPS+1];
    logic [31:0]      sq_root_reg [SQ_STEPS+1];

    // three dividers side by side: one quotient bit per stage
    logic             dv_vld_reg  [DIV_STEPS+1];
    q_item_t          dv_it_reg   [DIV_STEPS+1];
    logic [31:0]      dv_s_reg    [DIV_STEPS+1];
    logic [2:0][31:0] dv_rem_reg  [DIV_STEPS+1];
    logic [2:0][30:0] dv_n_reg    [DIV_STEPS+1];
    logic [2:0][30:0] dv_q_reg    [DIV_STEPS+1];

    logic             a1_vld_reg, a2_vld_reg, a3_vld_reg, a4_vld_reg;
    logic [2:0][31:0] a1_acc_reg;
    logic [2:0][31:0] a1_pos_reg, a2_pos_reg, a3_pos_reg;
    logic [2:0][31:0] a1_vel_reg, a2_vel_reg, a3_vel_reg;
    logic [2:0][56:0] a2_prod_reg;
    logic [2:0][31:0] a3_vn_reg;
    spi_out_t         res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_STEPS; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                dv_vld_reg[k] <= 1'b0;
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
            a3_vld_reg <= 1'b0;
            a4_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= in_vld;
            for (int k = 0; k < SQ_STEPS; k++)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            a1_vld_reg <= dv_vld_reg[DIV_STEPS];
            a2_vld_reg <= a1_vld_reg;
            a3_vld_reg <= a2_vld_reg;
            a4_vld_reg <= a3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [35:0] rsh;
        logic [35:0] trial;
        logic [32:0] dsh;
        sq_it_reg[0]   <= in_item;
        sq_v_reg[0]    <= in_item.sum;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            rsh   = {sq_rem_reg[k], sq_v_reg[k][63:62]};
            trial = {2'b00, sq_root_reg[k], 2'b01};
            sq_it_reg[k+1] <= sq_it_reg[k];
            sq_v_reg[k+1]  <= {sq_v_reg[k][61:0], 2'b00};
            if (rsh >= trial)
            begin
                sq_rem_reg[k+1]  <= 34'(rsh - trial);
                sq_root_reg[k+1] <= {sq_root_reg[k][30:0], 1'b1};
            end
            else
            begin
                sq_rem_reg[k+1]  <= rsh[33:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][30:0], 1'b0};
            end
        end

        // quotient fits 31 bits, so the top numerator bits seed the remainder
        dv_it_reg[0] <= sq_it_reg[SQ_STEPS];
        dv_s_reg[0]  <= sq_root_reg[SQ_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= {1'b0, sq_it_reg[SQ_STEPS].num[i][61:31]};
            dv_n_reg[0][i]   <= sq_it_reg[SQ_STEPS].num[i][30:0];
            dv_q_reg[0][i]   <= '0;
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_it_reg[k+1] <= dv_it_reg[k];
            dv_s_reg[k+1]  <= dv_s_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                dsh = {dv_rem_reg[k][i], dv_n_reg[k][i][30]};
                dv_n_reg[k+1][i] <= {dv_n_reg[k][i][29:0], 1'b0};
                if (dsh >= {1'b0, dv_s_reg[k]})
                begin
                    dv_rem_reg[k+1][i] <= 32'(dsh - {1'b0, dv_s_reg[k]});
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][29:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[k+1][i] <= dsh[31:0];
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [47:0] q;
        logic signed [47:0] ac;
        logic signed [24:0] rnd;
        logic signed [47:0] vsum;
        logic signed [33:0] esum;
        logic signed [35:0] v3;
        logic signed [47:0] psum;
        logic signed [47:0] ev [3];
        logic signed [47:0] pn [3];
        for (int i = 0; i < 3; i++)
        begin
            // limited acceleration plus walls and gravity
            q  = 48'($signed({1'b0, dv_q_reg[DIV_STEPS][i]}));
            if (dv_it_reg[DIV_STEPS].clamp)
                ac = dv_it_reg[DIV_STEPS].neg[i] ? -q : q;
            else
                ac = 48'($signed(dv_it_reg[DIV_STEPS].acc[i]));
            a1_acc_reg[i] <= sat32(ac + $signed(dv_it_reg[DIV_STEPS].extra[i]));
            a1_pos_reg[i] <= dv_it_reg[DIV_STEPS].pos[i];
            a1_vel_reg[i] <= dv_it_reg[DIV_STEPS].vel[i];

            a2_prod_reg[i] <= 57'($signed(a1_acc_reg[i])) * 57'(DT_Q32);
            a2_pos_reg[i]  <= a1_pos_reg[i];
            a2_vel_reg[i]  <= a1_vel_reg[i];

            rnd  = 25'(($signed(a2_prod_reg[i]) + (57'sd1 <<< 31)) >>> 32);
            vsum = 48'($signed(a2_vel_reg[i])) + 48'(rnd);
            a3_vn_reg[i]  <= sat32(vsum);
            a3_pos_reg[i] <= a2_pos_reg[i];
            a3_vel_reg[i] <= a2_vel_reg[i];

            esum = 34'($signed(a3_vel_reg[i])) + 34'($signed(a3_vn_reg[i])) + 34'sd1;
            ev[i] = 48'(esum >>> 1);
            v3   = 36'($signed(a3_vn_reg[i])) * 36'sd3 + 36'sd4;
            psum = 48'($signed(a3_pos_reg[i])) + 48'(v3 >>> 3);
            pn[i] = 48'(sat32(psum));
        end
        res_reg.new_pos_x  <= pn[0][31:0];
        res_reg.new_pos_y  <= pn[1][31:0];
        res_reg.new_pos_z  <= pn[2][31:0];
        res_reg.new_vel_x  <= a3_vn_reg[0];
        res_reg.new_vel_y  <= a3_vn_reg[1];
        res_reg.new_vel_z  <= a3_vn_reg[2];
        res_reg.new_eval_x <= ev[0][31:0];
        res_reg.new_eval_y <= ev[1][31:0];
        res_reg.new_eval_z <= ev[2][31:0];
    end

    assign done = a4_vld_reg;
    assign res  = res_reg;

endmodule

>>> rtl/sph_particle_integrate.sv
// sph_particle_integrate: one leapfrog time step for one fluid particle
//
// request channel: req carries position, half-step velocity, evaluated
// velocity and fluid acceleration, all signed q16.16; a request is taken
// at a rising edge with start high and busy low
// result channel: done is high for one cycle while res holds the new
// position, velocity and evaluated velocity; the receiver cannot stall,
// so results leave the pipeline as they finish
// configuration: cfg_we, cfg_idx, cfg_data write one register per cycle
// (walls, packed q8.8 gravity, acceleration limit); write only when idle
// throughput: one request per cycle; busy only rises if the small queue
// between classifier and datapath is almost full, which cannot happen while
// the datapath drains one entry per cycle
// path from the accepting edge to done: the front register, the queue, the
// 32-stage square root, the 31-stage limit dividers and the update registers
// reset: control and configuration registers clear, limit returns to 300.0, queue empties
module sph_particle_integrate
    import spi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  spi_in_t     req,
    output logic        done,
    output spi_out_t    res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [47:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    take;
    logic    push;
    q_item_t push_item;
    q_item_t pop_item;
    logic    q_empty;
    logic    q_afull;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{lo: '0, hi: '0, grav: '0, limit: LIMIT_RESET};
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_idx))
                REG_WALL_MIN_X:  cfg_reg.lo[0] <= cfg_data[31:0];
                REG_WALL_MIN_Y:  cfg_reg.lo[1] <= cfg_data[31:0];
                REG_WALL_MIN_Z:  cfg_reg.lo[2] <= cfg_data[31:0];
                REG_WALL_MAX_X:  cfg_reg.hi[0] <= cfg_data[31:0];
                REG_WALL_MAX_Y:  cfg_reg.hi[1] <= cfg_data[31:0];
                REG_WALL_MAX_Z:  cfg_reg.hi[2] <= cfg_data[31:0];
                REG_GRAVITY:     cfg_reg.grav  <= cfg_data;
                REG_ACCEL_LIMIT: cfg_reg.limit <= cfg_data[30:0];
                default:         cfg_reg       <= cfg_reg;
            endcase
        end
    end

    assign busy = q_afull;
    assign take = start && !busy;

    // front: squares, limit check, wall and gravity terms
    spi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .cfg       (cfg_reg),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    spi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (!q_empty),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .afull     (q_afull)
    );

    // back: magnitude limit, leapfrog update
    spi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (!q_empty),
        .in_item (pop_item),
        .done    (done),
        .res     (res)
    );

endmodule
